### sv/brmc_pkg.sv
// ----------------------------------------------------------------------------
// brmc_pkg
// Shared types and codes for the bit range move and compare engine.
// ----------------------------------------------------------------------------
package brmc_pkg;

	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_READ    = 2'd1;
	localparam logic [1:0] MODE_MOVE    = 2'd2;
	localparam logic [1:0] MODE_COMPARE = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       start;
		logic       check;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       cap_en;
		logic [1:0] cap_sel;
		logic       wr_en;
		logic       wr_sel;
		logic       eval;
		logic       adv;
		logic       finish;
	} brmc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic skip;
		logic last;
		logic stop;
		logic out_busy;
	} brmc_sts_t;

endpackage

### sv/brmc_ctrl.sv
// ----------------------------------------------------------------------------
// brmc_ctrl
// Sequencer: per step four byte reads, two write slots and an evaluate cycle.
// ----------------------------------------------------------------------------
module brmc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  brmc_pkg::brmc_sts_t sts,
	output brmc_pkg::brmc_cmd_t cmd
);
	import brmc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_WR0  = 3'd3;
	localparam logic [2:0] S_WR1  = 3'd4;
	localparam logic [2:0] S_NEXT = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] ph_q, ph_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		ph_d    = ph_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_CHK;
				end
			end
			S_CHK: begin
				cmd.check = 1'b1;
				ph_d      = 3'd0;
				state_d   = sts.skip ? S_OUT : S_RD;
			end
			S_RD: begin
				// Read data is registered, so it comes back in the cycle after the address.
				cmd.rd_en   = (ph_q != 3'd4);
				cmd.rd_sel  = ph_q[1:0];
				cmd.cap_en  = (ph_q != 3'd0);
				cmd.cap_sel = 2'(ph_q - 3'd1);
				ph_d        = 3'(ph_q + 3'd1);
				if (ph_q == 3'd4) begin
					state_d = S_WR0;
				end
			end
			S_WR0: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = 1'b0;
				state_d    = S_WR1;
			end
			S_WR1: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = 1'b1;
				state_d    = S_NEXT;
			end
			S_NEXT: begin
				cmd.eval = 1'b1;
				ph_d     = 3'd0;
				if (sts.last || sts.stop) begin
					state_d = S_OUT;
				end else begin
					cmd.adv = 1'b1;
					state_d = S_RD;
				end
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= 3'd0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
		end
	end

endmodule

### sv/brmc_dp.sv
// ----------------------------------------------------------------------------
// brmc_dp
// Byte store, operand registers, address generation, bit alignment and
// merge, and the result registers.
// ----------------------------------------------------------------------------
module brmc_dp #(
	parameter int MEM_BYTES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  brmc_pkg::brmc_cmd_t cmd,
	output brmc_pkg::brmc_sts_t sts,
	input  logic [1:0]          mode,
	input  logic [14:0]         src_bit,
	input  logic [14:0]         dst_bit,
	input  logic [15:0]         bit_count,
	input  logic [7:0]          data_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          read_byte,
	output logic                equal,
	output logic                range_error
);
	import brmc_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam int TW = AW + 3;
	localparam int XW = ((TW > 16) ? TW : 16) + 2;
	localparam logic [XW-1:0] TOTAL = XW'(MEM_BYTES * 8);
	localparam logic [XW-1:0] NBYTES = XW'(MEM_BYTES);

	logic [7:0] mem [MEM_BYTES];

	logic [1:0]    mode_q;
	logic [XW-1:0] src_q, dst_q, cnt_q, idx_q;
	logic [7:0]    data_q;
	logic [7:0]    r_q [4];
	logic [7:0]    rdata_q;
	logic          rok_q;
	logic [7:0]    res_rd_q;
	logic          res_eq_q, res_err_q;
	logic          out_valid_q;
	logic [7:0]    out_rd_q;
	logic          out_eq_q, out_err_q;

	logic          err, nowork, up;
	logic [XW-1:0] dlast, bfirst, blast, d0, s0, sc, dc, off8, rem;
	logic [2:0]    lo, hi;
	logic [XW-1:0] a [4];
	logic [XW-1:0] ra, wa;
	logic [15:0]   wwin, srcwin, cwin_s, cwin_d;
	logic [7:0]    srcbits, placed, mmask, cmask, cs, cd, rb, mv_new;
	logic [15:0]   wr_new, m16;
	logic [3:0]    n;
	logic          we, mism;
	logic [7:0]    wd;

	always_comb begin
		err = 1'b0;
		case (mode_q)
			MODE_WRITE: err = (dst_q + XW'(8)) > TOTAL;
			MODE_READ:  err = (src_q + XW'(8)) > TOTAL;
			default:    err = ((src_q + cnt_q) > TOTAL) || ((dst_q + cnt_q) > TOTAL);
		endcase
		nowork = ((mode_q == MODE_MOVE) && ((cnt_q == '0) || (src_q == dst_q)))
			|| ((mode_q == MODE_COMPARE) && (cnt_q == '0));
		up     = src_q > dst_q;

		// Move: one destination byte per step.
		dlast   = dst_q + cnt_q - XW'(1);
		bfirst  = dst_q >> 3;
		blast   = dlast >> 3;
		lo      = (idx_q == bfirst) ? dst_q[2:0] : 3'd0;
		hi      = (idx_q == blast) ? dlast[2:0] : 3'd7;
		d0      = (idx_q << 3) + XW'(lo);
		s0      = d0 + src_q - dst_q;
		srcwin  = {r_q[2], r_q[1]};
		srcbits = 8'(srcwin >> s0[2:0]);
		placed  = srcbits << lo;
		mmask   = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
		mv_new  = (r_q[0] & ~mmask) | (placed & mmask);

		// Compare: eight bits per step.
		off8   = idx_q << 3;
		sc     = src_q + off8;
		dc     = dst_q + off8;
		rem    = cnt_q - off8;
		n      = (rem >= XW'(8)) ? 4'd8 : rem[3:0];
		m16    = ~(16'hFFFF << n);
		cmask  = m16[7:0];
		cwin_s = {r_q[1], r_q[0]};
		cwin_d = {r_q[3], r_q[2]};
		cs     = 8'(cwin_s >> sc[2:0]);
		cd     = 8'(cwin_d >> dc[2:0]);
		mism   = ((cs ^ cd) & cmask) != 8'h00;

		// Byte write and byte read.
		wwin   = {r_q[1], r_q[0]};
		wr_new = (wwin & ~(16'h00FF << dst_q[2:0])) | ({8'h00, data_q} << dst_q[2:0]);
		rb     = 8'(wwin >> src_q[2:0]);

		case (mode_q)
			MODE_WRITE: begin
				a[0] = dst_q >> 3;
				a[1] = (dst_q >> 3) + XW'(1);
				a[2] = a[0];
				a[3] = a[0];
			end
			MODE_READ: begin
				a[0] = src_q >> 3;
				a[1] = (src_q >> 3) + XW'(1);
				a[2] = a[0];
				a[3] = a[0];
			end
			MODE_MOVE: begin
				a[0] = idx_q;
				a[1] = s0 >> 3;
				a[2] = (s0 >> 3) + XW'(1);
				a[3] = idx_q;
			end
			default: begin
				a[0] = sc >> 3;
				a[1] = (sc >> 3) + XW'(1);
				a[2] = dc >> 3;
				a[3] = (dc >> 3) + XW'(1);
			end
		endcase
		ra = a[cmd.rd_sel];

		we = 1'b0;
		wd = 8'h00;
		wa = a[0];
		case (mode_q)
			MODE_WRITE: begin
				we = cmd.wr_sel ? (dst_q[2:0] != 3'd0) : 1'b1;
				wd = cmd.wr_sel ? wr_new[15:8] : wr_new[7:0];
				wa = cmd.wr_sel ? a[1] : a[0];
			end
			MODE_MOVE: begin
				we = !cmd.wr_sel;
				wd = mv_new;
			end
			default: begin
				we = 1'b0;
			end
		endcase

		sts.skip     = err || nowork;
		sts.stop     = (mode_q == MODE_COMPARE) && mism;
		case (mode_q)
			MODE_MOVE:    sts.last = up ? (idx_q == blast) : (idx_q == bfirst);
			MODE_COMPARE: sts.last = rem <= XW'(8);
			default:      sts.last = 1'b1;
		endcase
		sts.out_busy = out_valid_q && !out_ready;
	end

	// Byte store: one read and one write port, registered read data.
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[ra[AW-1:0]];
			rok_q   <= ra < NBYTES;
		end
		if (cmd.wr_en && we && (wa < NBYTES)) begin
			mem[wa[AW-1:0]] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= mode;
			src_q  <= XW'(src_bit);
			dst_q  <= XW'(dst_bit);
			cnt_q  <= XW'(bit_count);
			data_q <= data_byte;
		end
		if (cmd.cap_en) begin
			// Bytes past the end of the store read as zero.
			r_q[cmd.cap_sel] <= rok_q ? rdata_q : 8'h00;
		end
		if (cmd.check) begin
			if (mode_q == MODE_MOVE) begin
				idx_q <= up ? bfirst : blast;
			end else begin
				idx_q <= '0;
			end
		end else if (cmd.adv) begin
			if ((mode_q == MODE_MOVE) && !up) begin
				idx_q <= idx_q - XW'(1);
			end else begin
				idx_q <= idx_q + XW'(1);
			end
		end
		if (cmd.start) begin
			res_rd_q  <= 8'h00;
			res_eq_q  <= 1'b0;
			res_err_q <= 1'b0;
		end else if (cmd.check) begin
			res_err_q <= err;
			res_eq_q  <= (mode_q == MODE_COMPARE) && !err;
		end else if (cmd.eval) begin
			if (mode_q == MODE_READ) begin
				res_rd_q <= rb;
			end
			if ((mode_q == MODE_COMPARE) && mism) begin
				res_eq_q <= 1'b0;
			end
		end
		if (cmd.finish) begin
			out_rd_q  <= res_rd_q;
			out_eq_q  <= res_eq_q;
			out_err_q <= res_err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_byte   = out_rd_q;
	assign equal       = out_eq_q;
	assign range_error = out_err_q;

endmodule

### sv/bit_range_move_compare_engine_unit.sv
// ----------------------------------------------------------------------------
// bit_range_move_compare_engine_unit
// Bit addressed byte store with byte write, byte read, bit move and compare.
// ----------------------------------------------------------------------------
//  channel | signals                                              | dir
//  in      | in_valid in_ready mode src_bit dst_bit bit_count data_byte | in
//  out     | out_valid out_ready read_byte equal range_error      | out
//
// Every step has four byte reads through the single read port, two write
// slots and an evaluate cycle. Write and read byte take one step, move one
// step per destination byte touched, compare one step per eight bits (it
// stops at the first mismatch); an out of range item or one with no work
// takes no step. Reset clears only control state; the store holds garbage
// until written. A new item is taken while the previous result still waits on out_ready.
module bit_range_move_compare_engine_unit #(
	parameter int MEM_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [14:0] src_bit,
	input  logic [14:0] dst_bit,
	input  logic [15:0] bit_count,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_byte,
	output logic        equal,
	output logic        range_error
);
	import brmc_pkg::*;

	brmc_cmd_t cmd;
	brmc_sts_t sts;

	brmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	brmc_dp #(
		.MEM_BYTES (MEM_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.src_bit     (src_bit),
		.dst_bit     (dst_bit),
		.bit_count   (bit_count),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_byte   (read_byte),
		.equal       (equal),
		.range_error (range_error)
	);

endmodule
